// ===== rtl/core/rfo_pkg.sv =====
package rfo_pkg;

  localparam int unsigned POS_W   = 20;  // signed Q12.8 position
  localparam int unsigned DIM_W   = 19;  // unsigned Q11.8 size
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned RD_W    = 9;   // read address fields
  localparam int unsigned CFG_W   = 10;  // widest config register
  localparam int unsigned SUM_W   = 22;  // position plus size, with headroom

  typedef enum logic [1:0] {
    MODE_FILL    = 2'd0,
    MODE_OUTLINE = 2'd1,
    MODE_READ    = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SIZE_ERR  = 2'd1,
    ST_RANGE_ERR = 2'd2
  } status_e;

  localparam logic [1:0] REG_CANVAS_W = 2'd0;
  localparam logic [1:0] REG_CANVAS_H = 2'd1;
  localparam logic [1:0] REG_BG       = 2'd2;

  // Integer pixel bound currently being worked out by the bound unit
  typedef enum logic [1:0] {
    BND_X_LO = 2'd0,
    BND_X_HI = 2'd1,
    BND_Y_LO = 2'd2,
    BND_Y_HI = 2'd3
  } bnd_step_e;

endpackage

// ===== rtl/core/rfo_bound_unit.sv =====
// Shared add and shift: turns one fixed-point edge into an integer pixel bound.
// Low edges round up (ceil), high edges round down (floor).
module rfo_bound_unit #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  rfo_pkg::bnd_step_e                step_i,
  input  logic signed [rfo_pkg::POS_W-1:0]  rect_x_i,
  input  logic signed [rfo_pkg::POS_W-1:0]  rect_y_i,
  input  logic        [rfo_pkg::DIM_W-1:0]  rect_width_i,
  input  logic        [rfo_pkg::DIM_W-1:0]  rect_height_i,
  output logic signed [rfo_pkg::SUM_W-1:0]  bound_o
);
  import rfo_pkg::*;

  localparam logic [DIM_W-1:0] RoundUp = DIM_W'((1 << FRAC_BITS) - 1);

  logic signed [POS_W-1:0] base;
  logic        [DIM_W-1:0] addend;
  logic signed [SUM_W-1:0] sum;

  always_comb begin
    unique case (step_i)
      BND_X_LO: begin
        base   = rect_x_i;
        addend = RoundUp;
      end
      BND_X_HI: begin
        base   = rect_x_i;
        addend = rect_width_i;
      end
      BND_Y_LO: begin
        base   = rect_y_i;
        addend = RoundUp;
      end
      BND_Y_HI: begin
        base   = rect_y_i;
        addend = rect_height_i;
      end
      default: begin
        base   = rect_x_i;
        addend = RoundUp;
      end
    endcase
  end

  assign sum     = SUM_W'(base) + $signed(SUM_W'(addend));
  assign bound_o = sum >>> FRAC_BITS;

endmodule

// ===== rtl/core/rfo_frame_mem.sv =====
// Frame store: one write port, one read port with registered data.
module rfo_frame_mem #(
  parameter int unsigned ADDR_W = 18
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ADDR_W-1:0]           waddr_i,
  input  logic [rfo_pkg::COLOR_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [ADDR_W-1:0]           raddr_i,
  output logic [rfo_pkg::COLOR_W-1:0] rdata_o
);
  import rfo_pkg::*;

  logic [COLOR_W-1:0] mem_q [1 << ADDR_W];
  logic [COLOR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rectangle_fill_outline_raster.sv =====
// Rectangle rasteriser over a MAX_SIDE x MAX_SIDE byte frame store. One command per
// transfer, one result per command. A draw first has the shared bound unit turn the
// fixed-point edges into integer pixel bounds (low and high x, then low and high y),
// then visits each pixel of the active canvas at one pixel per cycle through the store's
// single write port. A clear writes the background colour to every pixel of the store.
// The block takes no new command until the current one is finished; a finished result
// waits in the output register while the next command is taken.
// The store is undefined after reset until the first clear command.
module rectangle_fill_outline_raster #(
  parameter int unsigned MAX_SIDE  = 512,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [rfo_pkg::CFG_W-1:0]          cfg_wdata_i,
  // command channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         mode_i,
  input  logic signed [rfo_pkg::POS_W-1:0]   rect_x_i,
  input  logic signed [rfo_pkg::POS_W-1:0]   rect_y_i,
  input  logic [rfo_pkg::DIM_W-1:0]          rect_width_i,
  input  logic [rfo_pkg::DIM_W-1:0]          rect_height_i,
  input  logic [rfo_pkg::COLOR_W-1:0]        pen_color_i,
  input  logic [rfo_pkg::RD_W-1:0]           read_col_i,
  input  logic [rfo_pkg::RD_W-1:0]           read_row_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         status_o,
  output logic [rfo_pkg::COLOR_W-1:0]        pixel_value_o
);
  import rfo_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_SIDE);
  localparam int unsigned AW   = 2 * CW;
  localparam int unsigned CMPW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_BOUND,
    S_SCAN,
    S_CLEAR,
    S_READ,
    S_READ_DATA,
    S_DONE
  } state_e;

  // configuration registers
  logic [CFG_W-1:0]   canvas_w_q, canvas_h_q;
  logic [COLOR_W-1:0] bg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_w_q <= CFG_W'(1);
      canvas_h_q <= CFG_W'(1);
      bg_q       <= COLOR_W'(32);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CANVAS_W: canvas_w_q <= cfg_wdata_i;
        REG_CANVAS_H: canvas_h_q <= cfg_wdata_i;
        REG_BG:       bg_q       <= cfg_wdata_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // effective canvas size: zero acts as one, clamp to MAX_SIDE
  logic [CMPW-1:0] cw_eff, ch_eff;

  always_comb begin
    if (canvas_w_q == '0) begin
      cw_eff = CMPW'(1);
    end else if (CMPW'(canvas_w_q) > CMPW'(MAX_SIDE)) begin
      cw_eff = CMPW'(MAX_SIDE);
    end else begin
      cw_eff = CMPW'(canvas_w_q);
    end
    if (canvas_h_q == '0) begin
      ch_eff = CMPW'(1);
    end else if (CMPW'(canvas_h_q) > CMPW'(MAX_SIDE)) begin
      ch_eff = CMPW'(MAX_SIDE);
    end else begin
      ch_eff = CMPW'(canvas_h_q);
    end
  end

  state_e                  state_q;
  mode_e                   mode_q;
  logic signed [POS_W-1:0] x_q, y_q;
  logic [DIM_W-1:0]        w_q, h_q;
  logic [COLOR_W-1:0]      color_q;
  logic [RD_W-1:0]         rd_col_q, rd_row_q;
  bnd_step_e               step_q;
  logic signed [SUM_W-1:0] xlo_q, xhi_q, ylo_q, yhi_q;
  logic [CW-1:0]           col_q, row_q;
  status_e                 res_status_q;
  logic [COLOR_W-1:0]      res_pixel_q;
  logic                    out_valid_q;
  logic [1:0]              status_q;
  logic [COLOR_W-1:0]      pixel_q;

  logic signed [SUM_W-1:0] bound;

  rfo_bound_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) u_bound (
    .step_i       (step_q),
    .rect_x_i     (x_q),
    .rect_y_i     (y_q),
    .rect_width_i (w_q),
    .rect_height_i(h_q),
    .bound_o      (bound)
  );

  // scan position against the integer bounds
  logic signed [SUM_W-1:0] col_s, row_s;
  logic                    in_rect, on_edge;
  logic [CMPW-1:0]         lim_c, lim_r;
  logic                    col_last, row_last;
  logic                    rd_outside;

  assign col_s   = $signed(SUM_W'(col_q));
  assign row_s   = $signed(SUM_W'(row_q));
  assign in_rect = (col_s >= xlo_q) && (col_s <= xhi_q) &&
                   (row_s >= ylo_q) && (row_s <= yhi_q);
  // less than one unit from an edge is exactly the first or last covered pixel
  assign on_edge = (col_s == xlo_q) || (col_s == xhi_q) ||
                   (row_s == ylo_q) || (row_s == yhi_q);

  assign lim_c    = (state_q == S_CLEAR) ? CMPW'(MAX_SIDE - 1) : cw_eff - CMPW'(1);
  assign lim_r    = (state_q == S_CLEAR) ? CMPW'(MAX_SIDE - 1) : ch_eff - CMPW'(1);
  assign col_last = (CMPW'(col_q) == lim_c);
  assign row_last = (CMPW'(row_q) == lim_r);

  assign rd_outside = (CMPW'(rd_col_q) >= cw_eff) || (CMPW'(rd_row_q) >= ch_eff);

  // frame store access
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [COLOR_W-1:0] mem_wdata, mem_rdata;

  assign mem_we    = (state_q == S_CLEAR) ||
                     ((state_q == S_SCAN) && in_rect && ((mode_q == MODE_FILL) || on_edge));
  assign mem_waddr = {row_q, col_q};
  assign mem_wdata = (state_q == S_CLEAR) ? bg_q : color_q;
  assign mem_re    = (state_q == S_READ);
  assign mem_raddr = {CW'(rd_row_q), CW'(rd_col_q)};

  rfo_frame_mem #(
    .ADDR_W(AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // result register takes the finished command once it is free or being drained
  logic out_load;

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= BND_X_LO;
      col_q        <= '0;
      row_q        <= '0;
      res_status_q <= ST_OK;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        status_q    <= res_status_q;
        pixel_q     <= res_pixel_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            mode_q   <= mode_e'(mode_i);
            x_q      <= rect_x_i;
            y_q      <= rect_y_i;
            w_q      <= rect_width_i;
            h_q      <= rect_height_i;
            color_q  <= pen_color_i;
            rd_col_q <= read_col_i;
            rd_row_q <= read_row_i;
            state_q  <= S_DECODE;
          end
        end
        S_DECODE: begin
          col_q       <= '0;
          row_q       <= '0;
          res_pixel_q <= '0;
          unique case (mode_q)
            MODE_READ: begin
              if (rd_outside) begin
                res_status_q <= ST_RANGE_ERR;
                state_q      <= S_DONE;
              end else begin
                state_q <= S_READ;
              end
            end
            MODE_CLEAR: begin
              res_status_q <= ST_OK;
              state_q      <= S_CLEAR;
            end
            default: begin
              if (w_q == '0 || h_q == '0) begin
                res_status_q <= ST_SIZE_ERR;
                state_q      <= S_DONE;
              end else begin
                res_status_q <= ST_OK;
                step_q       <= BND_X_LO;
                state_q      <= S_BOUND;
              end
            end
          endcase
        end
        S_BOUND: begin
          unique case (step_q)
            BND_X_LO: begin
              xlo_q  <= bound;
              step_q <= BND_X_HI;
            end
            BND_X_HI: begin
              xhi_q  <= bound;
              step_q <= BND_Y_LO;
            end
            BND_Y_LO: begin
              ylo_q  <= bound;
              step_q <= BND_Y_HI;
            end
            BND_Y_HI: begin
              yhi_q   <= bound;
              state_q <= S_SCAN;
            end
            default: step_q <= BND_X_LO;
          endcase
        end
        S_SCAN, S_CLEAR: begin
          if (col_last) begin
            col_q <= '0;
            if (row_last) begin
              state_q <= S_DONE;
            end else begin
              row_q <= row_q + CW'(1);
            end
          end else begin
            col_q <= col_q + CW'(1);
          end
        end
        S_READ: begin
          state_q <= S_READ_DATA;
        end
        S_READ_DATA: begin
          res_status_q <= ST_OK;
          res_pixel_q  <= mem_rdata;
          state_q      <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign pixel_value_o = pixel_q;

  // a command transfer always moves the sequencer on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_DECODE)
    else $error("command transfer did not start decode");

  // results only come out of the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result raised outside done state");

  // scan counters stay inside the visited area
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_CLEAR) |->
      (CMPW'(col_q) <= lim_c) && (CMPW'(row_q) <= lim_r))
    else $error("scan counter beyond canvas");

  // a rejected size never reaches the scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> (w_q != '0) && (h_q != '0))
    else $error("zero-size rectangle being drawn");

  // error results carry no pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> pixel_value_o == '0)
    else $error("error result with nonzero pixel");

endmodule
